// ===== sv/ppdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Display command parser package
// Shared constants, field selects and controller/datapath link structures.
// ----------------------------------------------------------------------------
`default_nettype none

package ppdc_pkg;

    localparam int TEXT_CAPACITY = 64;
    localparam int COMMAND_COUNT = 7;
    localparam int STORE_DEPTH   = TEXT_CAPACITY - 1;
    localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int LEN_W    = 6;
    localparam int CODE_W   = 3;
    localparam int DELAY_W  = 16;
    localparam int COLOUR_W = 8;
    localparam int BYTE_W   = 8;

    localparam logic [LEN_W-1:0] BOGUS_LEN = LEN_W'(5);

    typedef enum logic [3:0] {
        FLD_CODE,
        FLD_D1,
        FLD_D2,
        FLD_FR,
        FLD_FG,
        FLD_FB,
        FLD_BR,
        FLD_BG,
        FLD_BB
    } t_field;

    typedef struct packed {
        logic              store;
        logic              acc_en;
        t_field            acc_sel;
        logic [BYTE_W-1:0] data;
        logic              pub_start;
        logic              bogus;
        logic              emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic last_item;
        logic fill_next;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== sv/ppdc_if.sv =====
// ----------------------------------------------------------------------------
// Display command parser channels
// Byte input channel and command output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppdc_in_if;
    logic                        valid;
    logic                        ready;
    logic [ppdc_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface ppdc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          last;
    logic [ppdc_pkg::BYTE_W-1:0]   text_char;
    logic [ppdc_pkg::LEN_W-1:0]    char_total;
    logic [ppdc_pkg::CODE_W-1:0]   command_code;
    logic [ppdc_pkg::DELAY_W-1:0]  first_delay;
    logic [ppdc_pkg::DELAY_W-1:0]  second_delay;
    logic [ppdc_pkg::COLOUR_W-1:0] fore_red;
    logic [ppdc_pkg::COLOUR_W-1:0] fore_green;
    logic [ppdc_pkg::COLOUR_W-1:0] fore_blue;
    logic [ppdc_pkg::COLOUR_W-1:0] back_red;
    logic [ppdc_pkg::COLOUR_W-1:0] back_green;
    logic [ppdc_pkg::COLOUR_W-1:0] back_blue;

    modport source (output valid, output last, output text_char, output char_total,
                    output command_code, output first_delay, output second_delay,
                    output fore_red, output fore_green, output fore_blue,
                    output back_red, output back_green, output back_blue,
                    input ready);
    modport sink   (input valid, input last, input text_char, input char_total,
                    input command_code, input first_delay, input second_delay,
                    input fore_red, input fore_green, input fore_blue,
                    input back_red, input back_green, input back_blue,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/ppdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Display command parser controller
// Line automaton over character classes and publish sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module ppdc_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [ppdc_pkg::BYTE_W-1:0] i_byte,
    output ppdc_pkg::t_dp_cmd                o_cmd,
    input  wire ppdc_pkg::t_dp_status        i_status
);

    localparam logic [4:0] ST_TEXT     = 5'd0;
    localparam logic [4:0] ST_CODE_BAR = 5'd1;
    localparam logic [4:0] ST_FLD_MIN  = 5'd2;
    localparam logic [4:0] ST_FLD_LAST = 5'd16;
    localparam logic [4:0] ST_BG_END   = 5'd17;
    localparam logic [4:0] ST_BB       = 5'd18;
    localparam logic [4:0] ST_IGN      = 5'd19;
    localparam logic [4:0] ST_EOC      = 5'd20;
    localparam logic [4:0] ST_ERR      = 5'd21;
    localparam logic [4:0] ST_EOE      = 5'd22;
    localparam logic [4:0] ST_DRAIN    = 5'd23;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_PIPE  = 8'd124;
    localparam logic [7:0] CH_D0    = 8'd48;
    localparam logic [7:0] CH_D9    = 8'd57;

    typedef enum logic [2:0] {
        CL_TEXT,
        CL_DIGIT,
        CL_PIPE,
        CL_CR,
        CL_NL,
        CL_BAD
    } t_class;

    typedef enum logic {
        M_PARSE,
        M_PUB
    } t_mode;

    function automatic t_class classify(logic [7:0] c);
        t_class cl;
        priority if (c == CH_NL)                   cl = CL_NL;
        else if (c == CH_CR)                       cl = CL_CR;
        else if (c < CH_SPACE || c > CH_TILDE)     cl = CL_BAD;
        else if (c == CH_PIPE)                     cl = CL_PIPE;
        else if (c >= CH_D0 && c <= CH_D9)         cl = CL_DIGIT;
        else                                       cl = CL_TEXT;
        return cl;
    endfunction

    function automatic logic [4:0] next_state(logic [4:0] s, t_class cl);
        logic [4:0] n;
        n = ST_ERR;
        if (s == ST_TEXT) begin
            if (cl == CL_TEXT || cl == CL_DIGIT) n = ST_TEXT;
            else if (cl == CL_PIPE)              n = ST_CODE_BAR;
        end else if (s >= ST_CODE_BAR && s <= ST_FLD_LAST) begin
            if (cl == CL_DIGIT)     n = s[0] ? s + 5'd1 : s;
            else if (cl == CL_PIPE) n = s[0] ? s + 5'd2 : s + 5'd1;
        end else if (s == ST_BG_END || s == ST_BB || s == ST_IGN) begin
            if (cl == CL_NL)                         n = ST_EOC;
            else if (cl == CL_CR)                    n = ST_IGN;
            else if (cl == CL_DIGIT && s != ST_IGN)  n = ST_BB;
        end else begin
            if (cl == CL_NL) n = ST_EOE;
        end
        return n;
    endfunction

    t_mode      r_mode, n_mode;
    logic [4:0] r_parse, n_parse;
    logic [4:0] s_eff;
    logic [4:0] n_st;
    logic       take;

    always_comb begin
        take    = i_valid && (r_mode == M_PARSE);
        s_eff   = (r_parse > ST_DRAIN) ? ST_TEXT : r_parse;
        n_st    = next_state(s_eff, classify(i_byte));
        n_mode  = r_mode;
        n_parse = r_parse;

        o_cmd           = '0;
        o_cmd.data      = i_byte;
        o_cmd.acc_sel   = ppdc_pkg::t_field'(n_st[4:1] - 4'd1);
        o_cmd.emit      = (r_mode == M_PUB);

        if (take) begin
            if (r_parse == ST_DRAIN) begin
                if (i_byte == CH_NUL || i_byte == CH_NL) n_parse = ST_TEXT;
            end else if (i_byte == CH_NUL || n_st == ST_EOC) begin
                o_cmd.pub_start = 1'b1;
                n_mode          = M_PUB;
                n_parse         = ST_TEXT;
            end else if (n_st == ST_EOE) begin
                o_cmd.pub_start = 1'b1;
                o_cmd.bogus     = 1'b1;
                n_mode          = M_PUB;
                n_parse         = ST_TEXT;
            end else begin
                n_parse = n_st;
                if (n_st == ST_TEXT) begin
                    o_cmd.store = 1'b1;
                    if (i_status.fill_next) begin
                        o_cmd.pub_start = 1'b1;
                        n_mode          = M_PUB;
                        n_parse         = ST_DRAIN;
                    end
                end else if (n_st >= ST_FLD_MIN && n_st <= ST_BB && !n_st[0]) begin
                    o_cmd.acc_en = 1'b1;
                end
            end
        end

        if (r_mode == M_PUB && i_status.out_free && i_status.last_item) begin
            n_mode = M_PARSE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_PARSE;
            r_parse <= ST_TEXT;
        end else begin
            r_mode  <= n_mode;
            r_parse <= n_parse;
        end
    end

    assign o_ready = (r_mode == M_PARSE);

endmodule

`default_nettype wire

// ===== sv/ppdc_dp.sv =====
// ----------------------------------------------------------------------------
// Display command parser datapath
// Text store, saturating decimal accumulators and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppdc_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ppdc_pkg::t_dp_cmd              i_cmd,
    output ppdc_pkg::t_dp_status                o_status,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_last,
    output logic [ppdc_pkg::BYTE_W-1:0]         o_text_char,
    output logic [ppdc_pkg::LEN_W-1:0]          o_char_total,
    output logic [ppdc_pkg::CODE_W-1:0]         o_command_code,
    output logic [ppdc_pkg::DELAY_W-1:0]        o_first_delay,
    output logic [ppdc_pkg::DELAY_W-1:0]        o_second_delay,
    output logic [ppdc_pkg::COLOUR_W-1:0]       o_fore_red,
    output logic [ppdc_pkg::COLOUR_W-1:0]       o_fore_green,
    output logic [ppdc_pkg::COLOUR_W-1:0]       o_fore_blue,
    output logic [ppdc_pkg::COLOUR_W-1:0]       o_back_red,
    output logic [ppdc_pkg::COLOUR_W-1:0]       o_back_green,
    output logic [ppdc_pkg::COLOUR_W-1:0]       o_back_blue
);

    localparam int LW = ppdc_pkg::LEN_W;
    localparam int AW = ppdc_pkg::ADDR_W;
    localparam int DW = ppdc_pkg::DELAY_W;
    localparam int CW = ppdc_pkg::COLOUR_W;

    function automatic logic [7:0] bogus_char(logic [2:0] k);
        logic [7:0] ch;
        unique case (k)
            3'd0:    ch = 8'd66;
            3'd1:    ch = 8'd79;
            3'd2:    ch = 8'd71;
            3'd3:    ch = 8'd85;
            3'd4:    ch = 8'd83;
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    logic [7:0]    r_mem [ppdc_pkg::STORE_DEPTH];
    logic [7:0]    r_rd_data;

    logic [LW-1:0] r_count;
    logic [7:0]    r_code_acc;
    logic [DW-1:0] r_delay  [2];
    logic [CW-1:0] r_colour [6];

    logic [LW-1:0] r_len;
    logic [ppdc_pkg::CODE_W-1:0] r_code_pub;
    logic          r_bogus;
    logic [LW-1:0] r_k;
    logic          r_o_valid;

    logic          out_free;
    logic          ld;
    logic          last_item;
    logic [LW-1:0] n_count;
    logic [LW-1:0] k_next;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] sel_acc;
    logic [DW-1:0] ceil;
    logic [19:0]   prod;
    logic [DW-1:0] sat;
    logic [ppdc_pkg::CODE_W-1:0] code_ok;

    always_comb begin
        out_free  = !r_o_valid || i_ready;
        ld        = i_cmd.emit && out_free;
        last_item = (r_k == r_len);
        n_count   = r_count + LW'(i_cmd.store);
        k_next    = r_k + LW'(1);
        wr_addr   = r_count[AW-1:0];

        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cmd.pub_start) begin
            rd_en = 1'b1;
        end else if (ld && !last_item && k_next < r_len) begin
            rd_en   = 1'b1;
            rd_addr = k_next[AW-1:0];
        end

        unique case (i_cmd.acc_sel)
            ppdc_pkg::FLD_CODE: sel_acc = DW'(r_code_acc);
            ppdc_pkg::FLD_D1:   sel_acc = r_delay[0];
            ppdc_pkg::FLD_D2:   sel_acc = r_delay[1];
            ppdc_pkg::FLD_FR:   sel_acc = DW'(r_colour[0]);
            ppdc_pkg::FLD_FG:   sel_acc = DW'(r_colour[1]);
            ppdc_pkg::FLD_FB:   sel_acc = DW'(r_colour[2]);
            ppdc_pkg::FLD_BR:   sel_acc = DW'(r_colour[3]);
            ppdc_pkg::FLD_BG:   sel_acc = DW'(r_colour[4]);
            ppdc_pkg::FLD_BB:   sel_acc = DW'(r_colour[5]);
            default:            sel_acc = '0;
        endcase
        ceil = (i_cmd.acc_sel == ppdc_pkg::FLD_D1 || i_cmd.acc_sel == ppdc_pkg::FLD_D2)
             ? {DW{1'b1}} : DW'(8'hFF);
        prod = {1'b0, sel_acc, 3'b000} + {3'b000, sel_acc, 1'b0} + 20'(i_cmd.data[3:0]);
        sat  = (prod > 20'(ceil)) ? ceil : prod[DW-1:0];

        code_ok = (r_code_acc >= 8'(ppdc_pkg::COMMAND_COUNT))
                ? '0 : r_code_acc[ppdc_pkg::CODE_W-1:0];

        o_status.out_free  = out_free;
        o_status.last_item = last_item;
        o_status.fill_next = (r_count == LW'(ppdc_pkg::STORE_DEPTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[wr_addr] <= i_cmd.data;
        end
        if (rd_en) begin
            if (i_cmd.store && wr_addr == rd_addr) begin
                r_rd_data <= i_cmd.data;
            end else begin
                r_rd_data <= r_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_code_acc <= '0;
            r_delay    <= '{default: '0};
            r_colour   <= '{default: '0};
            r_len      <= '0;
            r_code_pub <= '0;
            r_bogus    <= 1'b0;
            r_k        <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (ld && last_item) begin
                r_count    <= '0;
                r_code_acc <= '0;
                r_delay    <= '{default: '0};
                r_colour   <= '{default: '0};
            end else begin
                r_count <= n_count;
                if (i_cmd.acc_en) begin
                    unique case (i_cmd.acc_sel)
                        ppdc_pkg::FLD_CODE: r_code_acc  <= sat[7:0];
                        ppdc_pkg::FLD_D1:   r_delay[0]  <= sat;
                        ppdc_pkg::FLD_D2:   r_delay[1]  <= sat;
                        ppdc_pkg::FLD_FR:   r_colour[0] <= sat[CW-1:0];
                        ppdc_pkg::FLD_FG:   r_colour[1] <= sat[CW-1:0];
                        ppdc_pkg::FLD_FB:   r_colour[2] <= sat[CW-1:0];
                        ppdc_pkg::FLD_BR:   r_colour[3] <= sat[CW-1:0];
                        ppdc_pkg::FLD_BG:   r_colour[4] <= sat[CW-1:0];
                        ppdc_pkg::FLD_BB:   r_colour[5] <= sat[CW-1:0];
                        default:            r_code_acc  <= r_code_acc;
                    endcase
                end
            end

            if (i_cmd.pub_start) begin
                r_len      <= i_cmd.bogus ? ppdc_pkg::BOGUS_LEN : n_count;
                r_code_pub <= i_cmd.bogus ? '0 : code_ok;
                r_bogus    <= i_cmd.bogus;
                r_k        <= '0;
            end else if (ld) begin
                r_k <= k_next;
            end

            if (ld) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            o_last         <= last_item;
            o_text_char    <= last_item ? 8'd0
                            : (r_bogus ? bogus_char(r_k[2:0]) : r_rd_data);
            o_char_total   <= r_len;
            o_command_code <= r_code_pub;
            o_first_delay  <= r_delay[0];
            o_second_delay <= r_delay[1];
            o_fore_red     <= r_colour[0];
            o_fore_green   <= r_colour[1];
            o_fore_blue    <= r_colour[2];
            o_back_red     <= r_colour[3];
            o_back_green   <= r_colour[4];
            o_back_blue    <= r_colour[5];
        end
    end

    assign o_valid = r_o_valid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LW'(ppdc_pkg::STORE_DEPTH))
        else $error("text count beyond store depth");

    a_clear_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && last_item) |=> (r_count == '0 && r_code_acc == '0))
        else $error("accumulators not cleared after final transfer");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_k <= r_len))
        else $error("publish index overran length");

    a_bogus_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_bogus) |-> (r_len == ppdc_pkg::BOGUS_LEN))
        else $error("error line published with wrong length");

endmodule

`default_nettype wire

// ===== sv/pipe_delimited_display_command_parser.sv =====
// ----------------------------------------------------------------------------
// Pipe delimited display command parser
// Parses text|cmd|d1|d2|fr|fg|fb|br|bg|bb lines into display commands.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one raw byte per transfer. While parsing, one byte is taken
//   every cycle; a byte that only advances the line automaton gives no result.
//   A newline after the last colour, a newline in an error line, a zero byte,
//   or the text store filling publishes a command on o_out: one transfer per
//   text byte, then a final transfer with last set and the decoded fields.
//   The first result passes the mode register and then the output register
//   after the terminating byte; while a command drains, i_in is held off,
//   as the single text store read port feeds the output register one
//   text byte at a time. Throughput is otherwise one byte/cycle.
//   Reset returns the automaton to the text state and clears all fields and
//   the text count; the text store needs no clearing.
//   When the receiver stalls, the output register holds its transfer and the
//   drain pauses; once the final transfer is loaded, parsing of the next line
//   continues while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module pipe_delimited_display_command_parser (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ppdc_in_if.sink     i_in,
    ppdc_out_if.source  o_out
);

    ppdc_pkg::t_dp_cmd    dp_cmd;
    ppdc_pkg::t_dp_status dp_status;

    ppdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_byte   (i_in.in_byte),
        .o_cmd    (dp_cmd),
        .i_status (dp_status)
    );

    ppdc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_last         (o_out.last),
        .o_text_char    (o_out.text_char),
        .o_char_total   (o_out.char_total),
        .o_command_code (o_out.command_code),
        .o_first_delay  (o_out.first_delay),
        .o_second_delay (o_out.second_delay),
        .o_fore_red     (o_out.fore_red),
        .o_fore_green   (o_out.fore_green),
        .o_fore_blue    (o_out.fore_blue),
        .o_back_red     (o_out.back_red),
        .o_back_green   (o_out.back_green),
        .o_back_blue    (o_out.back_blue)
    );

endmodule

`default_nettype wire
